FILE: sv/mcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrc_pkg: shared types, constants and CRC byte-step functions
// Holds the polynomials, initial values and one-byte unrolled update
// functions used by the multi-CRC engine.
// ----------------------------------------------------------------------------
package mcrc_pkg;

    localparam logic [15:0] CRC16_POLY  = 16'h1021;
    localparam logic [15:0] CRC16_INIT  = 16'hFFFF;
    localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC32_INIT  = 32'hFFFF_FFFF;

    // enable mask bit positions
    localparam int EN_CRC16  = 0;
    localparam int EN_CRC32  = 1;
    localparam int EN_CRC32C = 2;

    typedef logic [2:0] mask_t;

    // one registered input beat handed to the CRC state unit
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } beat_t;

    // finished values for one end-of-stream beat
    typedef struct packed {
        logic [31:0] crc32c;
        logic [31:0] crc32;
        logic [15:0] crc16;
        mask_t       mask;
    } result_t;

    // CRC-16/CCITT-FALSE, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // reflected 32-bit CRC, LSB first, one byte
    function automatic logic [31:0] crc32r_byte(input logic [31:0] crc,
                                                input logic [7:0]  data,
                                                input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'h000000, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ({1'b0, c[31:1]} ^ poly) : {1'b0, c[31:1]};
        end
        return c;
    endfunction

endpackage

FILE: sv/mcrc_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrc_state: running CRC registers
// Advances the enabled CRCs by one byte per data beat, presents finished
// values on an end beat and reloads all three initial values.
// ----------------------------------------------------------------------------
module mcrc_state (
    input  logic              aclk,
    input  logic              aresetn,
    input  mcrc_pkg::beat_t   beat,
    input  mcrc_pkg::mask_t   mask,
    output mcrc_pkg::result_t result
);
    import mcrc_pkg::*;

    logic [15:0] crc16_reg,  crc16_next;
    logic [31:0] crc32_reg,  crc32_next;
    logic [31:0] crc32c_reg, crc32c_next;

    always_comb begin
        crc16_next  = crc16_reg;
        crc32_next  = crc32_reg;
        crc32c_next = crc32c_reg;
        if (beat.valid) begin
            if (beat.last) begin
                crc16_next  = CRC16_INIT;
                crc32_next  = CRC32_INIT;
                crc32c_next = CRC32_INIT;
            end else begin
                if (mask[EN_CRC16])
                    crc16_next = crc16_byte(crc16_reg, beat.data);
                if (mask[EN_CRC32])
                    crc32_next = crc32r_byte(crc32_reg, beat.data, CRC32_POLY);
                if (mask[EN_CRC32C])
                    crc32c_next = crc32r_byte(crc32c_reg, beat.data, CRC32C_POLY);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc16_reg  <= CRC16_INIT;
            crc32_reg  <= CRC32_INIT;
            crc32c_reg <= CRC32_INIT;
        end else begin
            crc16_reg  <= crc16_next;
            crc32_reg  <= crc32_next;
            crc32c_reg <= crc32c_next;
        end
    end

    // disabled CRCs report zero
    assign result.crc16  = mask[EN_CRC16]  ? crc16_reg                 : 16'h0000;
    assign result.crc32  = mask[EN_CRC32]  ? (crc32_reg ^ CRC32_INIT)  : 32'h0;
    assign result.crc32c = mask[EN_CRC32C] ? (crc32c_reg ^ CRC32_INIT) : 32'h0;
    assign result.mask   = mask;

endmodule

FILE: sv/multi_crc_byte_engine_top.sv
`timescale 1ns / 1ps
// A byte beat enters the input register on acceptance and updates the running
// CRCs in the following cycle; an end beat moves on to the result register
// (m_*) once that is free or being emptied. Throughput: one beat per cycle while
// no end beat waits, set by the unrolled byte update from input to CRC registers.
// Reset (aresetn low, synchronous): pipeline empty, enable mask 3'b111, all
// running CRCs at their initial values.
// ----------------------------------------------------------------------------
// multi_crc_byte_engine_top: CRC-16/CCITT-FALSE, CRC-32 and CRC-32C engine
// Byte stream in, one beat of finished CRCs out per end-of-stream beat.
// ----------------------------------------------------------------------------
module multi_crc_byte_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: enable mask
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,     // [0] CRC16, [1] CRC32, [2] CRC32C
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // end_of_stream, byte ignored
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,       // [15:0] crc16, [47:16] crc32, [79:48] crc32c
    output logic [2:0]  m_tuser        // [2:0] valid_mask
);
    import mcrc_pkg::*;

    // ---------------- configuration register ----------------
    mask_t mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 3'b111;
        end else if (cfg_we) begin
            mask_reg <= cfg_wdata;
        end
    end

    // ---------------- input register ----------------
    // A data beat never waits in the input register. An end beat drains only when
    // the result register is free or being emptied this cycle.
    logic       in_valid_reg;
    logic       in_last_reg;
    logic [7:0] in_data_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_last_reg <= s_tlast;
            in_data_reg <= s_tdata;
        end
    end

    // ---------------- running CRC state ----------------
    beat_t   beat;
    result_t result;

    assign beat.valid = advance;
    assign beat.last  = in_last_reg;
    assign beat.data  = in_data_reg;

    mcrc_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (beat),
        .mask    (mask_reg),
        .result  (result)
    );

    // ---------------- result register ----------------
    logic    out_valid_reg;
    result_t out_reg;
    logic    load_out;

    assign load_out = advance && in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.crc32c, out_reg.crc32, out_reg.crc16};
    assign m_tuser  = out_reg.mask;

`ifndef ASSERT_OFF
    // an end beat that leaves the input register must produce a result beat
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("end beat drained without a result");

    // a held end beat must not be lost or altered while output is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_last_reg)))
        else $error("stalled input beat dropped");

    // a disabled CRC16 always reports zero
    a_crc16_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[EN_CRC16]) |-> (m_tdata[15:0] == 16'h0000))
        else $error("disabled CRC16 reported nonzero");

    // after an end beat the CRC-32 state restarts: empty stream reports zero
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (u_state.crc32_reg == CRC32_INIT))
        else $error("CRC32 not reloaded after end beat");
`endif

endmodule

FILE: bench/multi_crc_byte_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_crc_byte_engine_top_test: self-checking bench for the multi-CRC engine
// Streams byte beats with random gaps and back-pressure. A local bitwise model
// of CRC-16/CCITT-FALSE, CRC-32 and CRC-32C predicts each end-of-stream result.
// Every result beat is checked field by field. The enable mask is rewritten
// between phases, including in the middle of a stream.
// ----------------------------------------------------------------------------
module multi_crc_byte_engine_top_test;
    import mcrc_pkg::*;

    localparam int CLK_HALF_NS   = 10;
    localparam int RESET_CYCLES  = 7;
    // settle margin after the last result comes back
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    // watchdog limit on a stretch with no beat, result or register write
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 1150;
    localparam int PHASES        = 10;

    // one input beat as the driver holds it
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } byte_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_wdata = 3'b111;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;

    // beats waiting for the driver, results waiting for the monitor
    byte_beat_t pending_beats[$];
    result_t    expected_crcs[$];

    // local copy of the engine state
    mask_t       crc_mask   = 3'b111;
    logic [15:0] crc16_run  = CRC16_INIT;
    logic [31:0] crc32_run  = CRC32_INIT;
    logic [31:0] crc32c_run = CRC32_INIT;

    // idle percentages for each side, set per phase
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    int          mismatches   = 0;
    int          quiet_cycles = 0;
    byte_beat_t  next_beat;
    result_t     want;

    multi_crc_byte_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #CLK_HALF_NS;
        aclk = 1'b0;
        #CLK_HALF_NS;
    end

    // CRC-16 MSB first, one data bit at a time against the top bit
    function automatic logic [15:0] ccitt_step(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
        end
        return c;
    endfunction

    // reflected 32-bit CRC, LSB of the byte first
    function automatic logic [31:0] reflected_step(input logic [31:0] crc,
                                                   input logic [7:0]  b,
                                                   input logic [31:0] poly);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = (c >> 1) ^ (fb ? poly : 32'h0000_0000);
        end
        return c;
    endfunction

    // Advance the running CRCs by one accepted beat. An end beat queues the
    // finished values (disabled fields read zero) and reloads all three CRCs.
    task automatic advance_crcs(input byte_beat_t beat);
        result_t fin;
        if (!beat.last) begin
            if (crc_mask[EN_CRC16])
                crc16_run = ccitt_step(crc16_run, beat.data);
            if (crc_mask[EN_CRC32])
                crc32_run = reflected_step(crc32_run, beat.data, CRC32_POLY);
            if (crc_mask[EN_CRC32C])
                crc32c_run = reflected_step(crc32c_run, beat.data, CRC32C_POLY);
        end else begin
            fin.crc16  = crc_mask[EN_CRC16]  ? crc16_run               : 16'h0000;
            fin.crc32  = crc_mask[EN_CRC32]  ? crc32_run ^ CRC32_INIT  : 32'h0;
            fin.crc32c = crc_mask[EN_CRC32C] ? crc32c_run ^ CRC32_INIT : 32'h0;
            fin.mask   = crc_mask;
            expected_crcs.push_back(fin);
            crc16_run  = CRC16_INIT;
            crc32_run  = CRC32_INIT;
            crc32c_run = CRC32_INIT;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_beat(input logic last, input logic [7:0] data);
        byte_beat_t b;
        b.last = last;
        b.data = data;
        pending_beats.push_back(b);
    endtask

    // Block until every queued beat is accepted and every result is back, then
    // let the pipeline drain a byte beat that produces no result.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || expected_crcs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mask writes only happen with the engine idle; the model follows at once
    // since no beat can be in flight.
    task automatic write_mask(input mask_t m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        crc_mask   = m;
    endtask

    // Driver: a beat stays up until taken; each take advances the model.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                advance_crcs({s_tlast, s_tdata});
            if (pending_beats.size() != 0 &&
                (tx_idle_pct == 0 || $urandom_range(99) >= tx_idle_pct)) begin
                next_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_beat.data;
                s_tlast  <= next_beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, every taken result checked in order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_crcs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata %h tuser %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_crcs.pop_front();
                    if (m_tdata[15:0] !== want.crc16)
                        report_mismatch($sformatf("crc16 got %h want %h",
                                                  m_tdata[15:0], want.crc16));
                    if (m_tdata[47:16] !== want.crc32)
                        report_mismatch($sformatf("crc32 got %h want %h",
                                                  m_tdata[47:16], want.crc32));
                    if (m_tdata[79:48] !== want.crc32c)
                        report_mismatch($sformatf("crc32c got %h want %h",
                                                  m_tdata[79:48], want.crc32c));
                    if (m_tuser !== want.mask)
                        report_mismatch($sformatf("valid_mask got %b want %b",
                                                  m_tuser, want.mask));
                end
            end
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: too long without any beat or register write means a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no progress for %0d cycles",
                         $realtime, QUIET_LIMIT);
                $display("multi_crc_byte_engine_top_test failed");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then random phases.
    initial begin
        string       check_str;
        int unsigned r;
        int unsigned mode;
        mask_t       m;
        check_str = "123456789";

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stream straight out of reset
        push_beat(1'b1, 8'h00);
        // standard check string, all three CRCs live
        for (int i = 0; i < 9; i++)
            push_beat(1'b0, check_str[i]);
        push_beat(1'b1, 8'hFF);
        // byte extremes
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b1, 8'h00);
        // nothing enabled: result still comes, all zero
        write_mask(3'b000);
        push_beat(1'b0, 8'hA5);
        push_beat(1'b1, 8'h00);
        // mask changes mid-stream, disabled CRCs hold and later resume
        write_mask(3'b101);
        push_beat(1'b0, 8'h5A);
        write_mask(3'b010);
        push_beat(1'b0, 8'h3C);
        write_mask(3'b111);
        push_beat(1'b0, 8'h81);
        push_beat(1'b1, 8'h00);

        // Random phases. Each phase picks a mask and an idling mode; a phase
        // may end mid-stream so the next write also lands inside a stream.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0, 8:    m = 3'b111;
                1:       m = 3'b000;
                2:       m = 3'b001;
                3:       m = 3'b010;
                4:       m = 3'b100;
                5:       m = 3'b011;
                6:       m = 3'b101;
                7:       m = 3'b110;
                default: m = mask_t'($urandom_range(7));
            endcase
            write_mask(m);
            mode = p % 4;
            case (mode)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 65;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 65;
                end
                default: begin
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
            endcase
            for (int n = 0; n < RANDOM_BEATS / PHASES; n++) begin
                r = $urandom_range(99);
                if (r < 12)
                    push_beat(1'b1, 8'($urandom));
                else if (r < 17)
                    push_beat(1'b0, 8'h00);
                else if (r < 22)
                    push_beat(1'b0, 8'hFF);
                else
                    push_beat(1'b0, 8'($urandom));
            end
        end
        // close the last stream so its CRCs are checked too
        push_beat(1'b1, 8'h00);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("multi_crc_byte_engine_top_test passed");
        else
            $display("multi_crc_byte_engine_top_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/mcrc_pkg.sv
sv/mcrc_state.sv
sv/multi_crc_byte_engine_top.sv
bench/multi_crc_byte_engine_top_test.sv
